/* rtl/atac_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package atac_pkg;

  localparam int FRAC_BITS_DEF    = 16;
  localparam int CORDIC_STEPS_DEF = 16;

  localparam logic [2:0] OP_IDENT     = 3'd0;
  localparam logic [2:0] OP_TRANSLATE = 3'd1;
  localparam logic [2:0] OP_SCALE     = 3'd2;
  localparam logic [2:0] OP_ROTATE    = 3'd3;
  localparam logic [2:0] OP_SKEW_X    = 3'd4;
  localparam logic [2:0] OP_SKEW_Y    = 3'd5;

  localparam int STEP_W = 6;
  localparam int ZW     = 35;
  localparam int XW     = 34;

  localparam logic signed [ZW-1:0] Q30_PI      = 35'sd3373259426;
  localparam logic signed [ZW-1:0] Q30_HALF_PI = 35'sd1686629713;
  localparam logic signed [XW-1:0] Q30_GAIN    = 34'sd652032874;

  localparam logic signed [31:0] ENTRY_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] ENTRY_MIN = 32'sh80000000;

  typedef struct packed {
    logic              load;
    logic              cor_init;
    logic              cor_step;
    logic              cor_fin;
    logic              div_init;
    logic              div_step;
    logic              tan_fin;
    logic              mul_en;
    logic [1:0]        mul_ph;
    logic [2:0]        ent;
    logic              commit;
    logic              out_load;
    logic [STEP_W-1:0] step;
  } atac_cmd_t;

  typedef struct packed {
    logic [2:0] op;
  } atac_stat_t;

  function automatic logic [29:0] atan_q30(input logic [4:0] idx);
    logic [29:0] v;
    case (idx)
      5'd0:  v = 30'd843314857;
      5'd1:  v = 30'd497837829;
      5'd2:  v = 30'd263043836;
      5'd3:  v = 30'd133525158;
      5'd4:  v = 30'd67021686;
      5'd5:  v = 30'd33543515;
      5'd6:  v = 30'd16775850;
      5'd7:  v = 30'd8388437;
      5'd8:  v = 30'd4194282;
      5'd9:  v = 30'd2097149;
      5'd10: v = 30'd1048575;
      5'd11: v = 30'd524287;
      5'd12: v = 30'd262143;
      5'd13: v = 30'd131071;
      5'd14: v = 30'd65535;
      5'd15: v = 30'd32767;
      5'd16: v = 30'd16383;
      5'd17: v = 30'd8191;
      5'd18: v = 30'd4095;
      5'd19: v = 30'd2047;
      5'd20: v = 30'd1023;
      5'd21: v = 30'd511;
      5'd22: v = 30'd255;
      5'd23: v = 30'd127;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

/* rtl/atac_if.sv */
`timescale 1ns / 1ps
`default_nettype none
interface atac_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         op;
  logic signed [31:0] operand_x;
  logic signed [31:0] operand_y;
  logic signed [18:0] angle;
  modport source (output valid, op, operand_x, operand_y, angle, input ready);
  modport sink (input valid, op, operand_x, operand_y, angle, output ready);
endinterface

interface atac_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] scale_x_entry;
  logic signed [31:0] shear_xy_entry;
  logic signed [31:0] move_x_entry;
  logic signed [31:0] shear_yx_entry;
  logic signed [31:0] scale_y_entry;
  logic signed [31:0] move_y_entry;
  logic               saturated;
  modport source (output valid, scale_x_entry, shear_xy_entry, move_x_entry,
                  shear_yx_entry, scale_y_entry, move_y_entry, saturated,
                  input ready);
  modport sink (input valid, scale_x_entry, shear_xy_entry, move_x_entry,
                shear_yx_entry, scale_y_entry, move_y_entry, saturated,
                output ready);
endinterface
`default_nettype wire

/* rtl/atac_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none
module atac_datapath import atac_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire atac_cmd_t          cmd,
  output atac_stat_t              stat,
  input  wire logic [2:0]         in_op,
  input  wire logic signed [31:0] in_operand_x,
  input  wire logic signed [31:0] in_operand_y,
  input  wire logic signed [18:0] in_angle,
  output logic signed [31:0]      out_entry [6],
  output logic                    out_saturated
);

  localparam int DVD_W = 33 + FRAC_BITS;
  localparam logic signed [31:0] ONE = 32'sd1 <<< FRAC_BITS;

  logic [2:0]         op_r;
  logic signed [31:0] ox_r, oy_r;
  logic signed [18:0] ang_r;

  logic signed [ZW-1:0] z_r;
  logic signed [XW-1:0] x_r, y_r;
  logic                 flip_r;
  logic signed [XW-1:0] c30_r, s30_r;
  logic signed [31:0]   cf_r, sf_r, tan_r;

  logic [XW-1:0]    rem_r;
  logic [DVD_W-1:0] quo_r;
  logic [32:0]      dvs_r;

  logic signed [63:0] p_r, acc_r;
  logic signed [64:0] sum_r;
  logic signed [31:0] ent_r [6];
  logic signed [31:0] res_r [6];
  logic signed [31:0] outv_r [6];
  logic               ovf_r, osat_r;

  assign stat.op = op_r;
  assign out_entry = outv_r;
  assign out_saturated = osat_r;

  // CORDIC rotation step and angle fold.
  logic [4:0]           sh;
  logic signed [XW-1:0] x_sh, y_sh;
  logic signed [ZW-1:0] atan_v, z0;
  assign sh     = cmd.step[4:0];
  assign x_sh   = x_r >>> sh;
  assign y_sh   = y_r >>> sh;
  assign atan_v = $signed({5'd0, atan_q30(sh)});
  assign z0     = $signed({{2{ang_r[18]}}, ang_r, 14'd0});

  // Rounding from Q4.30 down to the entry format.
  logic signed [XW:0] c_rnd, s_rnd, c_q, s_q;
  logic signed [XW-1:0] c_fl, s_fl;
  assign c_fl  = flip_r ? -x_r : x_r;
  assign s_fl  = flip_r ? -y_r : y_r;
  assign c_rnd = {c_fl[XW-1], c_fl} + ((XW+1)'(1) <<< (29 - FRAC_BITS));
  assign s_rnd = {s_fl[XW-1], s_fl} + ((XW+1)'(1) <<< (29 - FRAC_BITS));
  assign c_q   = c_rnd >>> (30 - FRAC_BITS);
  assign s_q   = s_rnd >>> (30 - FRAC_BITS);

  // Magnitude divider for the tangent.
  logic [XW-1:0] s_abs, c_abs, rem_sh;
  logic          rem_ge;
  assign s_abs  = s30_r[XW-1] ? XW'(-s30_r) : XW'(s30_r);
  assign c_abs  = c30_r[XW-1] ? XW'(-c30_r) : XW'(c30_r);
  assign rem_sh = {rem_r[XW-2:0], quo_r[DVD_W-1]};
  assign rem_ge = rem_sh >= {1'b0, dvs_r};

  logic               t_neg, t_ovf;
  logic signed [31:0] t_val;
  always_comb begin
    t_neg = s30_r[XW-1] ^ c30_r[XW-1];
    t_ovf = 1'b0;
    t_val = '0;
    if (c30_r == '0) begin
      t_ovf = 1'b1;
      t_val = s30_r[XW-1] ? ENTRY_MIN : ENTRY_MAX;
    end else if (t_neg) begin
      if ((|quo_r[DVD_W-1:32]) || (quo_r[31] && (|quo_r[30:0]))) begin
        t_ovf = 1'b1;
        t_val = ENTRY_MIN;
      end else begin
        t_val = -$signed(quo_r[31:0]);
      end
    end else if (|quo_r[DVD_W-1:31]) begin
      t_ovf = 1'b1;
      t_val = ENTRY_MAX;
    end else begin
      t_val = $signed(quo_r[31:0]);
    end
  end

  // Right-hand matrix, row-major, bottom row implied.
  logic signed [31:0] coef [6];
  always_comb begin
    for (int k = 0; k < 6; k++) coef[k] = '0;
    case (op_r)
      OP_TRANSLATE: begin
        coef[0] = ONE; coef[2] = ox_r; coef[4] = ONE; coef[5] = oy_r;
      end
      OP_SCALE: begin
        coef[0] = ox_r; coef[4] = oy_r;
      end
      OP_ROTATE: begin
        coef[0] = cf_r; coef[1] = -sf_r; coef[3] = sf_r; coef[4] = cf_r;
      end
      OP_SKEW_X: begin
        coef[0] = ONE; coef[1] = tan_r; coef[4] = ONE;
      end
      OP_SKEW_Y: begin
        coef[0] = ONE; coef[3] = tan_r; coef[4] = ONE;
      end
      default: ;
    endcase
  end

  logic               row;
  logic [1:0]         col;
  logic signed [31:0] m0, m1, m2, mop, cop, base;
  logic signed [63:0] prod;
  always_comb begin
    row = cmd.ent >= 3'd3;
    col = row ? 2'(cmd.ent - 3'd3) : cmd.ent[1:0];
    m0  = row ? ent_r[3] : ent_r[0];
    m1  = row ? ent_r[4] : ent_r[1];
    m2  = row ? ent_r[5] : ent_r[2];
    if (cmd.mul_ph == 2'd0) begin
      mop = m0;
      cop = coef[3'(col)];
    end else begin
      mop = m1;
      cop = coef[3'(col) + 3'd3];
    end
    base = (col == 2'd2) ? m2 : '0;
  end
  assign prod = mop * cop;

  // Round half up, add the old translation, saturate.
  logic signed [64:0] rnd, tot;
  logic signed [31:0] f_val;
  logic               f_ovf;
  always_comb begin
    rnd   = (sum_r >>> FRAC_BITS) + $signed({64'd0, sum_r[FRAC_BITS-1]});
    tot   = rnd + {{33{base[31]}}, base};
    f_ovf = 1'b0;
    f_val = tot[31:0];
    if (!sum_r[64] && sum_r[63]) begin
      f_ovf = 1'b1;
      f_val = ENTRY_MAX;
    end else if (tot > 65'sd2147483647) begin
      f_ovf = 1'b1;
      f_val = ENTRY_MAX;
    end else if (tot < -65'sd2147483648) begin
      f_ovf = 1'b1;
      f_val = ENTRY_MIN;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= in_op;
      ox_r  <= in_operand_x;
      oy_r  <= in_operand_y;
      ang_r <= in_angle;
    end
    if (cmd.cor_init) begin
      x_r <= Q30_GAIN;
      y_r <= '0;
      if (z0 > Q30_HALF_PI) begin
        z_r    <= z0 - Q30_PI;
        flip_r <= 1'b1;
      end else if (z0 < -Q30_HALF_PI) begin
        z_r    <= z0 + Q30_PI;
        flip_r <= 1'b1;
      end else begin
        z_r    <= z0;
        flip_r <= 1'b0;
      end
    end else if (cmd.cor_step) begin
      if (!z_r[ZW-1]) begin
        x_r <= x_r - y_sh;
        y_r <= y_r + x_sh;
        z_r <= z_r - atan_v;
      end else begin
        x_r <= x_r + y_sh;
        y_r <= y_r - x_sh;
        z_r <= z_r + atan_v;
      end
    end
    if (cmd.cor_fin) begin
      c30_r <= c_fl;
      s30_r <= s_fl;
      cf_r  <= c_q[31:0];
      sf_r  <= s_q[31:0];
    end
    if (cmd.div_init) begin
      rem_r <= '0;
      quo_r <= {s_abs[32:0], {FRAC_BITS{1'b0}}};
      dvs_r <= c_abs[32:0];
    end else if (cmd.div_step) begin
      rem_r <= rem_ge ? rem_sh - {1'b0, dvs_r} : rem_sh;
      quo_r <= {quo_r[DVD_W-2:0], rem_ge};
    end
    if (cmd.tan_fin) tan_r <= t_val;
    if (cmd.mul_en) begin
      case (cmd.mul_ph)
        2'd0: p_r <= prod;
        2'd1: begin
          acc_r <= p_r;
          p_r   <= prod;
        end
        2'd2: sum_r <= {acc_r[63], acc_r} + {p_r[63], p_r};
        default: res_r[cmd.ent] <= f_val;
      endcase
    end
    if (cmd.out_load) outv_r <= ent_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_r[0] <= ONE; ent_r[1] <= '0; ent_r[2] <= '0;
      ent_r[3] <= '0;  ent_r[4] <= ONE; ent_r[5] <= '0;
      ovf_r  <= 1'b0;
      osat_r <= 1'b0;
    end else begin
      if (cmd.tan_fin && t_ovf) ovf_r <= 1'b1;
      if (cmd.mul_en && cmd.mul_ph == 2'd3 && f_ovf) ovf_r <= 1'b1;
      if (cmd.commit) begin
        if (op_r == OP_IDENT) begin
          ent_r[0] <= ONE; ent_r[1] <= '0; ent_r[2] <= '0;
          ent_r[3] <= '0;  ent_r[4] <= ONE; ent_r[5] <= '0;
          ovf_r    <= 1'b0;
        end else begin
          ent_r <= res_r;
        end
      end
      if (cmd.out_load) osat_r <= ovf_r;
    end
  end

endmodule
`default_nettype wire

/* rtl/atac_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
module atac_ctrl import atac_pkg::*; #(
  parameter int FRAC_BITS    = FRAC_BITS_DEF,
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  wire logic       out_ready,
  input  wire atac_stat_t stat,
  output atac_cmd_t       cmd
);

  localparam int DVD_W = 33 + FRAC_BITS;
  localparam logic [STEP_W-1:0] COR_LAST = STEP_W'(CORDIC_STEPS - 1);
  localparam logic [STEP_W-1:0] DIV_LAST = STEP_W'(DVD_W - 1);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_START  = 4'd1;
  localparam logic [3:0] S_COR    = 4'd2;
  localparam logic [3:0] S_CFIN   = 4'd3;
  localparam logic [3:0] S_DINIT  = 4'd4;
  localparam logic [3:0] S_DIV    = 4'd5;
  localparam logic [3:0] S_TFIN   = 4'd6;
  localparam logic [3:0] S_MUL    = 4'd7;
  localparam logic [3:0] S_COMMIT = 4'd8;
  localparam logic [3:0] S_PUSH   = 4'd9;

  logic [3:0]        state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [2:0]        ent_r, ent_nxt;
  logic [1:0]        ph_r, ph_nxt;
  logic              ovld_r, ovld_nxt;
  logic              out_free;

  assign in_ready  = state_r == S_IDLE;
  assign out_valid = ovld_r;
  assign out_free  = !ovld_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    ent_nxt   = ent_r;
    ph_nxt    = ph_r;
    ovld_nxt  = ovld_r && !out_ready;
    cmd       = '0;
    cmd.step  = step_r;
    cmd.ent   = ent_r;
    cmd.mul_ph = ph_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_START;
        end
      end
      S_START: begin
        step_nxt = '0;
        ent_nxt  = '0;
        ph_nxt   = '0;
        case (stat.op) inside
          OP_IDENT: state_nxt = S_COMMIT;
          OP_TRANSLATE, OP_SCALE: state_nxt = S_MUL;
          OP_ROTATE, OP_SKEW_X, OP_SKEW_Y: begin
            cmd.cor_init = 1'b1;
            state_nxt    = S_COR;
          end
          default: state_nxt = S_PUSH;
        endcase
      end
      S_COR: begin
        cmd.cor_step = 1'b1;
        step_nxt     = step_r + 1'b1;
        if (step_r == COR_LAST) state_nxt = S_CFIN;
      end
      S_CFIN: begin
        cmd.cor_fin = 1'b1;
        state_nxt   = (stat.op == OP_ROTATE) ? S_MUL : S_DINIT;
      end
      S_DINIT: begin
        cmd.div_init = 1'b1;
        step_nxt     = '0;
        state_nxt    = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        step_nxt     = step_r + 1'b1;
        if (step_r == DIV_LAST) state_nxt = S_TFIN;
      end
      S_TFIN: begin
        cmd.tan_fin = 1'b1;
        state_nxt   = S_MUL;
      end
      S_MUL: begin
        // Four phases per entry: two products, the sum, then round and saturate.
        cmd.mul_en = 1'b1;
        ph_nxt     = ph_r + 1'b1;
        if (ph_r == 2'd3) begin
          ent_nxt = ent_r + 1'b1;
          if (ent_r == 3'd5) state_nxt = S_COMMIT;
        end
      end
      S_COMMIT: begin
        cmd.commit = 1'b1;
        state_nxt  = S_PUSH;
      end
      S_PUSH: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          ovld_nxt     = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r  <= '0;
      ent_r   <= '0;
      ph_r    <= '0;
      ovld_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      ent_r   <= ent_nxt;
      ph_r    <= ph_nxt;
      ovld_r  <= ovld_nxt;
    end
  end

endmodule
`default_nettype wire

/* rtl/affine_transform_accumulator_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// Channel   Direction  Contents
// in_if     in         op, operand_x, operand_y, angle
// out_if    out        six Q16.16 matrix entries, saturated flag
//
// One item at a time. Translate and scale work through the six entries on the
// one shared 32x32 multiplier; identity and unknown ops skip the multiplies.
// Rotate first runs the CORDIC; skews then also run the one-bit-per-cycle
// tangent divider. Reset loads the identity matrix and clears the flag. A
// stalled result stays in the output register while the next item is taken
// in and worked on.
module affine_transform_accumulator_core import atac_pkg::*; #(
  parameter int FRAC_BITS    = FRAC_BITS_DEF,
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input wire logic  clk,
  input wire logic  rst_n,
  atac_in_if.sink   in_if,
  atac_out_if.source out_if
);

  atac_cmd_t          cmd;
  atac_stat_t         stat;
  logic signed [31:0] entry [6];

  atac_ctrl #(
    .FRAC_BITS(FRAC_BITS),
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_ctrl (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_if.valid),
    .in_ready(in_if.ready),
    .out_valid(out_if.valid),
    .out_ready(out_if.ready),
    .stat(stat),
    .cmd(cmd)
  );

  atac_datapath #(
    .FRAC_BITS(FRAC_BITS)
  ) u_dp (
    .clk(clk),
    .rst_n(rst_n),
    .cmd(cmd),
    .stat(stat),
    .in_op(in_if.op),
    .in_operand_x(in_if.operand_x),
    .in_operand_y(in_if.operand_y),
    .in_angle(in_if.angle),
    .out_entry(entry),
    .out_saturated(out_if.saturated)
  );

  assign out_if.scale_x_entry  = entry[0];
  assign out_if.shear_xy_entry = entry[1];
  assign out_if.move_x_entry   = entry[2];
  assign out_if.shear_yx_entry = entry[3];
  assign out_if.scale_y_entry  = entry[4];
  assign out_if.move_y_entry   = entry[5];

endmodule
`default_nettype wire

/* dv/tb_affine_transform_accumulator_core.sv */
`timescale 1ns / 1ps
module tb_affine_transform_accumulator_core;
  import atac_pkg::*;

  localparam int FB = FRAC_BITS_DEF;
  localparam int CS = CORDIC_STEPS_DEF;
  localparam int N_RANDOM = 430;
  localparam int CALM_FROM = 380;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam logic [2:0] OP_UNKNOWN_A = 3'd6;
  localparam logic [2:0] OP_UNKNOWN_B = 3'd7;
  localparam longint ONE = longint'(1) << FB;
  localparam longint L_MAX = 64'sd2147483647;
  localparam longint L_MIN = -64'sd2147483648;

  typedef struct packed {
    logic signed [31:0] sx;
    logic signed [31:0] shxy;
    logic signed [31:0] mx;
    logic signed [31:0] shyx;
    logic signed [31:0] sy;
    logic signed [31:0] my;
    logic               sat;
  } matrix_t;

  typedef struct {
    logic [2:0]         op;
    logic signed [31:0] ox;
    logic signed [31:0] oy;
    logic signed [18:0] ang;
    bit                 typed;
    matrix_t            want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #6 clk = ~clk;

  atac_in_if  in_ch();
  atac_out_if out_ch();

  affine_transform_accumulator_core uut (
    .clk(clk), .rst_n(rst_n), .in_if(in_ch), .out_if(out_ch)
  );

  // Predictor state.
  longint mtx[6];
  bit     ovf;
  matrix_t expected_q[$];
  int     n_fail = 0;
  bit     calm = 1'b0;
  int     n_sent = 0;

  function automatic longint rnd_half_up(longint s);
    return (s >>> FB) + ((s >>> (FB - 1)) & 1);
  endfunction

  function automatic longint clamp32(longint v);
    if (v > L_MAX) begin ovf = 1'b1; return L_MAX; end
    if (v < L_MIN) begin ovf = 1'b1; return L_MIN; end
    return v;
  endfunction

  function automatic longint entry_sum(longint p1, longint p2, longint base);
    if (p1 > 0 && p2 > 64'sh7fffffffffffffff - p1) begin
      ovf = 1'b1;
      return L_MAX;
    end
    return clamp32(rnd_half_up(p1 + p2) + base);
  endfunction

  function automatic void apply_matrix(longint a, longint b, longint c,
                                       longint d, longint e, longint f);
    longint m0, m1, m2;
    for (int r = 0; r < 2; r++) begin
      m0 = mtx[r*3]; m1 = mtx[r*3+1]; m2 = mtx[r*3+2];
      mtx[r*3]   = entry_sum(m0 * a, m1 * d, 0);
      mtx[r*3+1] = entry_sum(m0 * b, m1 * e, 0);
      mtx[r*3+2] = entry_sum(m0 * c, m1 * f, m2);
    end
  endfunction

  function automatic void sin_cos_q30(longint ang, output longint c30, output longint s30);
    longint z, x, y, nx;
    bit flip;
    z = ang * 16384;
    x = longint'(Q30_GAIN);
    y = 0;
    flip = 1'b0;
    if (z > longint'(Q30_HALF_PI)) begin z -= longint'(Q30_PI); flip = 1'b1; end
    else if (z < -longint'(Q30_HALF_PI)) begin z += longint'(Q30_PI); flip = 1'b1; end
    for (int i = 0; i < CS && i < 24; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i); y = y + (x >>> i); z -= longint'(atan_q30(i));
      end else begin
        nx = x + (y >>> i); y = y - (x >>> i); z += longint'(atan_q30(i));
      end
      x = nx;
    end
    c30 = flip ? -x : x;
    s30 = flip ? -y : y;
  endfunction

  function automatic longint tan_fixed(longint ang);
    longint c30, s30;
    sin_cos_q30(ang, c30, s30);
    if (c30 == 0) begin
      ovf = 1'b1;
      return (s30 >= 0) ? L_MAX : L_MIN;
    end
    return clamp32((s30 * ONE) / c30);
  endfunction

  function automatic void load_identity();
    mtx[0] = ONE; mtx[1] = 0; mtx[2] = 0;
    mtx[3] = 0; mtx[4] = ONE; mtx[5] = 0;
    ovf = 1'b0;
  endfunction

  function automatic matrix_t next_transform(logic [2:0] op, logic signed [31:0] ox,
                                             logic signed [31:0] oy, logic signed [18:0] ang);
    longint c30, s30, c, s, t;
    matrix_t m;
    case (op)
      OP_IDENT: load_identity();
      OP_TRANSLATE: apply_matrix(ONE, 0, longint'(ox), 0, ONE, longint'(oy));
      OP_SCALE: apply_matrix(longint'(ox), 0, 0, 0, longint'(oy), 0);
      OP_ROTATE: begin
        sin_cos_q30(longint'(ang), c30, s30);
        c = (c30 + (longint'(1) << (29 - FB))) >>> (30 - FB);
        s = (s30 + (longint'(1) << (29 - FB))) >>> (30 - FB);
        apply_matrix(c, -s, 0, s, c, 0);
      end
      OP_SKEW_X: begin
        t = tan_fixed(longint'(ang));
        apply_matrix(ONE, t, 0, 0, ONE, 0);
      end
      OP_SKEW_Y: begin
        t = tan_fixed(longint'(ang));
        apply_matrix(ONE, 0, 0, t, ONE, 0);
      end
      default: ;
    endcase
    m.sx = mtx[0][31:0]; m.shxy = mtx[1][31:0]; m.mx = mtx[2][31:0];
    m.shyx = mtx[3][31:0]; m.sy = mtx[4][31:0]; m.my = mtx[5][31:0];
    m.sat = ovf;
    return m;
  endfunction

  function automatic matrix_t mk(longint a, longint b, longint c, longint d,
                                 longint e, longint f, bit s);
    matrix_t m;
    m.sx = a[31:0]; m.shxy = b[31:0]; m.mx = c[31:0];
    m.shyx = d[31:0]; m.sy = e[31:0]; m.my = f[31:0]; m.sat = s;
    return m;
  endfunction

  // Result checker.
  matrix_t got, want;
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.sx = out_ch.scale_x_entry; got.shxy = out_ch.shear_xy_entry;
      got.mx = out_ch.move_x_entry; got.shyx = out_ch.shear_yx_entry;
      got.sy = out_ch.scale_y_entry; got.my = out_ch.move_y_entry;
      got.sat = out_ch.saturated;
      if (expected_q.size() == 0) begin
        n_fail++;
        if (n_fail <= 10) $display("unexpected result item %p", got);
      end else begin
        want = expected_q.pop_front();
        if (got.sx !== want.sx || got.shxy !== want.shxy || got.mx !== want.mx ||
            got.shyx !== want.shyx || got.sy !== want.sy || got.my !== want.my ||
            got.sat !== want.sat) begin
          n_fail++;
          if (n_fail <= 10) $display("mismatch: expected %p, got %p", want, got);
        end
      end
    end
  end

  // Receiver stalls come in bursts.
  int stall_left = 0;
  initial out_ch.ready = 1'b0;
  always @(posedge clk) begin
    if (calm || !rst_n) begin
      out_ch.ready <= rst_n;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ch.ready <= 1'b0;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(1, 10) - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // Watchdog on cycles with no accepted item on either channel.
  int quiet = 0;
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= WATCHDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic send_item(logic [2:0] op, logic signed [31:0] ox, logic signed [31:0] oy,
                           logic signed [18:0] ang, bit typed, matrix_t tw);
    matrix_t p;
    in_ch.valid <= 1'b1;
    in_ch.op <= op; in_ch.operand_x <= ox; in_ch.operand_y <= oy; in_ch.angle <= ang;
    do @(posedge clk); while (!in_ch.ready);
    p = next_transform(op, ox, oy, ang);
    expected_q.push_back(typed ? tw : p);
    n_sent++;
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
  endtask

  function automatic logic signed [31:0] rand_operand();
    case ($urandom_range(0, 4))
      0: return $urandom();
      1: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
      2: return 32'(int'($urandom_range(0, 2 * ONE)) - int'(ONE));
      default: return 32'(int'($urandom_range(ONE / 2, 2 * ONE)) *
                          ($urandom_range(0, 1) ? 1 : -1));
    endcase
  endfunction

  stim_row_t rows[$];
  stim_row_t r;
  logic [2:0] rop;
  logic signed [18:0] rang;

  initial begin
    in_ch.valid = 1'b0; in_ch.op = OP_IDENT;
    in_ch.operand_x = '0; in_ch.operand_y = '0; in_ch.angle = '0;
    load_identity();
    rows = '{
      '{OP_UNKNOWN_A, 32'sh7fffffff, 32'sh80000000, 19'sh3ffff, 1, mk(ONE,0,0,0,ONE,0,0)},
      '{OP_IDENT, 32'sh12345678, 32'sh0, 19'sh0, 1, mk(ONE,0,0,0,ONE,0,0)},
      '{OP_TRANSLATE, 32'sh7fffffff, 32'sh80000000, 19'sh0, 1,
        mk(ONE,0,L_MAX,0,ONE,L_MIN,0)},
      '{OP_TRANSLATE, 32'sh00010000, 32'shffff0000, 19'sh0, 1,
        mk(ONE,0,L_MAX,0,ONE,L_MIN,1)},
      '{OP_IDENT, 32'sh0, 32'sh0, 19'sh0, 1, mk(ONE,0,0,0,ONE,0,0)},
      '{OP_SCALE, 32'sh7fffffff, 32'sh80000000, 19'sh0, 1,
        mk(L_MAX,0,0,0,L_MIN,0,0)},
      '{OP_SCALE, 32'sh7fffffff, 32'sh7fffffff, 19'sh0, 0, '0},
      '{OP_IDENT, 32'sh0, 32'sh0, 19'sh0, 1, mk(ONE,0,0,0,ONE,0,0)},
      '{OP_SCALE, 32'sh00020000, 32'sh00020000, 19'sh0, 0, '0},
      '{OP_ROTATE, 32'sh0, 32'sh0, 19'sh3ffff, 0, '0},
      '{OP_ROTATE, 32'sh0, 32'sh0, 19'sh40000, 0, '0},
      '{OP_ROTATE, 32'sh0, 32'sh0, 19'sh1921f, 0, '0},
      '{OP_ROTATE, 32'sh0, 32'sh0, 19'sh0, 0, '0},
      '{OP_SKEW_X, 32'sh0, 32'sh0, 19'sh0c90f, 0, '0},
      '{OP_SKEW_Y, 32'sh0, 32'sh0, 19'sh736f1, 0, '0},
      '{OP_SKEW_X, 32'sh0, 32'sh0, 19'sh1921f, 0, '0},
      '{OP_SKEW_Y, 32'sh0, 32'sh0, 19'sh66de1, 0, '0},
      '{OP_SKEW_X, 32'sh0, 32'sh0, 19'sh3ffff, 0, '0},
      '{OP_UNKNOWN_B, 32'sh0, 32'sh0, 19'sh0, 0, '0},
      '{OP_IDENT, 32'sh0, 32'sh0, 19'sh0, 1, mk(ONE,0,0,0,ONE,0,0)}
    };
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (rows[i]) begin
      r = rows[i];
      send_item(r.op, r.ox, r.oy, r.ang, r.typed, r.want);
    end
    for (int k = 0; k < N_RANDOM; k++) begin
      if (k == CALM_FROM) calm = 1'b1;
      if (k == N_RANDOM / 2) begin
        // Let the block drain completely once.
        in_ch.valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge clk);
      end
      case ($urandom_range(0, 19))
        0: rop = OP_IDENT;
        1: rop = $urandom_range(0, 1) ? OP_UNKNOWN_A : OP_UNKNOWN_B;
        default: rop = $urandom_range(OP_TRANSLATE, OP_SKEW_Y);
      endcase
      rang = ($urandom_range(0, 2) == 0) ? 19'($urandom()) :
             19'(int'($urandom_range(0, 2 * 51472)) - 51472);
      send_item(rop, rand_operand(), rand_operand(), rang, 0, '0);
    end
    in_ch.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (n_fail == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

/* affine_transform_accumulator_core.f */
rtl/atac_pkg.sv
rtl/atac_if.sv
rtl/atac_datapath.sv
rtl/atac_ctrl.sv
rtl/affine_transform_accumulator_core.sv
dv/tb_affine_transform_accumulator_core.sv
